### rtl/nps_pkg.sv
// ----------------------------------------------------------------------------
// Next permutation step package
// Shared widths, defaults and reset values for the next permutation core.
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int WORD_W          = 64;
    localparam int LEN_CFG_W       = 5;
    localparam int MAX_LEN_DEF     = 16;
    localparam int SYMBOL_BITS_DEF = 4;

    localparam logic [LEN_CFG_W-1:0] LEN_RESET = LEN_CFG_W'(10);

endpackage

### rtl/nps_pivot.sv
// ----------------------------------------------------------------------------
// Next permutation pivot finder
// Locates the rightmost symbol that is smaller than its right neighbor.
// ----------------------------------------------------------------------------
module nps_pivot import nps_pkg::*; #(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
    localparam int IDX_W      = $clog2(MAX_LEN),
    localparam int CNT_W      = $clog2(MAX_LEN + 1)
) (
    input  logic [WORD_W-1:0]      i_word,
    input  logic [CNT_W-1:0]       i_len,
    output logic                   o_found,
    output logic [IDX_W-1:0]       o_pivot_idx,
    output logic [SYMBOL_BITS-1:0] o_pivot_sym
);

    logic [SYMBOL_BITS-1:0] sym [MAX_LEN];

    always_comb begin
        for (int k = 0; k < MAX_LEN; k++) begin
            sym[k] = i_word[k*SYMBOL_BITS +: SYMBOL_BITS];
        end
    end

    always_comb begin
        o_found     = 1'b0;
        o_pivot_idx = '0;
        for (int k = 1; k < MAX_LEN; k++) begin
            if ((CNT_W'(k) < i_len) && (sym[k-1] < sym[k])) begin
                o_found     = 1'b1;
                o_pivot_idx = IDX_W'(k - 1);
            end
        end
    end

    assign o_pivot_sym = sym[o_pivot_idx];

endmodule

### rtl/nps_rearrange.sv
// ----------------------------------------------------------------------------
// Next permutation rearranger
// Swaps the pivot with its successor symbol and reverses the suffix.
// ----------------------------------------------------------------------------
module nps_rearrange import nps_pkg::*; #(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
    localparam int IDX_W      = $clog2(MAX_LEN),
    localparam int CNT_W      = $clog2(MAX_LEN + 1)
) (
    input  logic [WORD_W-1:0]      i_word,
    input  logic [CNT_W-1:0]       i_len,
    input  logic                   i_found,
    input  logic [IDX_W-1:0]       i_pivot_idx,
    input  logic [SYMBOL_BITS-1:0] i_pivot_sym,
    output logic [WORD_W-1:0]      o_perm,
    output logic                   o_is_last
);

    logic [SYMBOL_BITS-1:0] sym [MAX_LEN];
    logic [IDX_W-1:0]       succ_idx;

    always_comb begin
        for (int k = 0; k < MAX_LEN; k++) begin
            sym[k] = i_word[k*SYMBOL_BITS +: SYMBOL_BITS];
        end
    end

    always_comb begin
        succ_idx = i_pivot_idx;
        for (int k = 1; k < MAX_LEN; k++) begin
            if ((IDX_W'(k) > i_pivot_idx) && (CNT_W'(k) < i_len) &&
                (sym[k] > i_pivot_sym)) begin
                succ_idx = IDX_W'(k);
            end
        end
    end

    always_comb begin
        logic [CNT_W:0]   mirror;
        logic [IDX_W-1:0] src;
        o_perm = i_word;
        for (int k = 0; k < MAX_LEN; k++) begin
            mirror = (CNT_W+1)'(i_len) + (CNT_W+1)'(i_pivot_idx) - (CNT_W+1)'(k);
            src    = mirror[IDX_W-1:0];
            if (i_found && (CNT_W'(k) < i_len)) begin
                if (IDX_W'(k) == i_pivot_idx) begin
                    o_perm[k*SYMBOL_BITS +: SYMBOL_BITS] = sym[succ_idx];
                end else if (IDX_W'(k) > i_pivot_idx) begin
                    o_perm[k*SYMBOL_BITS +: SYMBOL_BITS] =
                        (src == succ_idx) ? i_pivot_sym : sym[src];
                end
            end
        end
    end

    assign o_is_last = ~i_found;

endmodule

### rtl/next_permutation_step_core.sv
// ----------------------------------------------------------------------------
// Next permutation step core
// Returns the next lexicographic permutation of a packed symbol sequence.
// ----------------------------------------------------------------------------
// The input channel carries one request per packed 64-bit sequence on
// i_perm_in, taken when i_in_valid is high and o_in_stall is low. Symbol k
// sits in bits k*SYMBOL_BITS upward and position 0 is the most significant.
// The output channel returns o_perm_out and o_is_last, taken when
// o_out_valid is high and i_out_stall is low.
// A request is captured in an input register and its result is then written
// into the output register, from which it is offered. One request is accepted
// every cycle while the receiver does not stall; the pivot search, swap and
// suffix reversal all fit between the two registers. When the receiver stalls,
// the held result stays put and one more request can still enter the input
// register; only then is o_in_stall raised. The sequence length is written
// through i_cfg_wr_en and i_cfg_wr_data; the user must write it only while
// the core is idle, which the core does not enforce. Values above MAX_LEN act
// as MAX_LEN. Reset empties both registers and sets the length to 10.
// ----------------------------------------------------------------------------
module next_permutation_step_core import nps_pkg::*; #(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [LEN_CFG_W-1:0] i_cfg_wr_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [WORD_W-1:0]    i_perm_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [WORD_W-1:0]    o_perm_out,
    output logic                 o_is_last
);

    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    logic [LEN_CFG_W-1:0]   r_len;
    logic                   r_s1_vld;
    logic [WORD_W-1:0]      r_word;
    logic                   r_out_vld;
    logic [WORD_W-1:0]      r_out_perm;
    logic                   r_out_last;

    logic [CNT_W-1:0]       len_eff;
    logic                   out_ready;
    logic                   in_fire;
    logic                   s1_fire;
    logic                   found;
    logic [IDX_W-1:0]       pivot_idx;
    logic [SYMBOL_BITS-1:0] pivot_sym;
    logic [WORD_W-1:0]      n_perm;
    logic                   n_last;

    assign len_eff   = (r_len > LEN_CFG_W'(MAX_LEN)) ? CNT_W'(MAX_LEN) : r_len[CNT_W-1:0];
    assign out_ready = ~r_out_vld | ~i_out_stall;
    assign s1_fire   = r_s1_vld & out_ready;
    assign o_in_stall = r_s1_vld & ~out_ready;
    assign in_fire   = i_in_valid & ~o_in_stall;

    nps_pivot #(
        .MAX_LEN     (MAX_LEN),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_pivot (
        .i_word      (r_word),
        .i_len       (len_eff),
        .o_found     (found),
        .o_pivot_idx (pivot_idx),
        .o_pivot_sym (pivot_sym)
    );

    nps_rearrange #(
        .MAX_LEN     (MAX_LEN),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_rearrange (
        .i_word      (r_word),
        .i_len       (len_eff),
        .i_found     (found),
        .i_pivot_idx (pivot_idx),
        .i_pivot_sym (pivot_sym),
        .o_perm      (n_perm),
        .o_is_last   (n_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= LEN_RESET;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_len <= i_cfg_wr_data;
            end
            if (in_fire) begin
                r_s1_vld <= 1'b1;
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_fire) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_word <= i_perm_in;
        end
        if (s1_fire) begin
            r_out_perm <= n_perm;
            r_out_last <= n_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_perm_out  = r_out_perm;
    assign o_is_last   = r_out_last;

    a_len_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        len_eff <= CNT_W'(MAX_LEN))
        else $error("effective length exceeds the maximum");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> (!r_s1_vld || out_ready))
        else $error("request accepted over an unsent item");

    a_held_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !out_ready) |=> (r_s1_vld && $stable(r_word)))
        else $error("stalled item lost from the input register");

    a_last_is_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> (!r_out_last || (r_out_perm == $past(r_word))))
        else $error("last permutation does not return its input");

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Next permutation step testbench
// Drives packed symbol sequences through the core under several sequence
// lengths and random flow control. A scoreboard predicts the successor of
// every accepted request and checks each returned result in order.
// ----------------------------------------------------------------------------
module tb_top;
    import nps_pkg::*;

    localparam int SB        = SYMBOL_BITS_DEF;
    localparam int NSYM      = MAX_LEN_DEF;
    localparam int IDLE_MAX  = 2000;
    localparam int PHASES    = 6;
    localparam int PHASE_REQ = 100;

    typedef struct packed {
        logic [WORD_W-1:0] perm;
        logic              last;
    } t_successor;

    class t_successor_book;
        logic [LEN_CFG_W-1:0] seq_len;
        t_successor           awaited[$];
        int                   errors;

        function new();
            seq_len = LEN_RESET;
            errors  = 0;
        endfunction

        function t_successor successor_of(logic [WORD_W-1:0] word);
            logic [SB-1:0] sym [NSYM];
            logic [SB-1:0] t;
            int            n, k, p, q, lo, hi;
            t_successor    r;
            n = (seq_len > NSYM) ? NSYM : int'(seq_len);
            for (k = 0; k < n; k++) begin
                sym[k] = word[SB*k +: SB];
            end
            p = -1;
            k = n - 1;
            while (k > 0 && p < 0) begin
                if (sym[k-1] < sym[k]) begin
                    p = k - 1;
                end
                k--;
            end
            r.perm = word;
            r.last = 1'b1;
            if (p >= 0) begin
                q = n - 1;
                while (sym[q] <= sym[p]) begin
                    q--;
                end
                t      = sym[p];
                sym[p] = sym[q];
                sym[q] = t;
                lo = p + 1;
                hi = n - 1;
                while (lo < hi) begin
                    t       = sym[lo];
                    sym[lo] = sym[hi];
                    sym[hi] = t;
                    lo++;
                    hi--;
                end
                for (k = 0; k < n; k++) begin
                    r.perm[SB*k +: SB] = sym[k];
                end
                r.last = 1'b0;
            end
            return r;
        endfunction

        function void note_request(logic [WORD_W-1:0] word);
            awaited.push_back(successor_of(word));
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [WORD_W-1:0] perm, logic last);
            t_successor e;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected result perm=%h last=%b", perm, last));
            end else begin
                e = awaited.pop_front();
                if (perm !== e.perm) begin
                    report($sformatf("perm got %h want %h", perm, e.perm));
                end
                if (last !== e.last) begin
                    report($sformatf("is_last got %b want %b (perm %h)", last, e.last, e.perm));
                end
            end
        endtask

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [LEN_CFG_W-1:0] i_cfg_wr_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [WORD_W-1:0]    i_perm_in;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [WORD_W-1:0]    o_perm_out;
    logic                 o_is_last;

    t_successor_book   book;
    logic              calm = 1'b0;
    logic [WORD_W-1:0] prev_word = '0;
    int                quiet_cycles = 0;

    next_permutation_step_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_perm_in     (i_perm_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_perm_out    (o_perm_out),
        .o_is_last     (o_is_last)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 25);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                book.note_request(i_perm_in);
            end
            if (o_out_valid && !i_out_stall) begin
                book.check_result(o_perm_out, o_is_last);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_MAX) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task send_request(input logic [WORD_W-1:0] word);
        while (!calm && $urandom_range(0, 99) < 25) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_perm_in  <= word;
        prev_word  = word;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
    endtask

    task wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (book.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task write_length(input logic [LEN_CFG_W-1:0] len);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(posedge i_clk);
        i_cfg_wr_en  <= 1'b0;
        book.seq_len = len;
    endtask

    function logic [WORD_W-1:0] make_word();
        logic [SB-1:0]     pool [NSYM];
        logic [SB-1:0]     t;
        logic [WORD_W-1:0] w;
        int                n, i, j, r;
        t_successor        s;
        n = (book.seq_len > NSYM) ? NSYM : int'(book.seq_len);
        w = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 20) begin
            return w;
        end else if (r < 60) begin
            for (i = 0; i < NSYM; i++) begin
                pool[i] = SB'(i);
            end
            for (i = NSYM - 1; i > 0; i--) begin
                j       = $urandom_range(0, i);
                t       = pool[i];
                pool[i] = pool[j];
                pool[j] = t;
            end
            for (i = 0; i < NSYM; i++) begin
                w[SB*i +: SB] = pool[i];
            end
        end else if (r < 80) begin
            j = $urandom_range(0, 13);
            for (i = 0; i < NSYM; i++) begin
                w[SB*i +: SB] = SB'(j + $urandom_range(0, 2));
            end
        end else if (r < 90) begin
            for (i = 0; i < n; i++) begin
                for (j = 0; j + 1 < n - i; j++) begin
                    if (w[SB*j +: SB] < w[SB*(j+1) +: SB]) begin
                        t                 = w[SB*j +: SB];
                        w[SB*j +: SB]     = w[SB*(j+1) +: SB];
                        w[SB*(j+1) +: SB] = t;
                    end
                end
            end
        end else begin
            s = book.successor_of(prev_word);
            w = s.perm;
        end
        return w;
    endfunction

    logic [LEN_CFG_W-1:0] phase_len [PHASES] = '{5'd16, 5'd3, 5'd5, 5'd31, 5'd12, 5'd2};

    initial begin
        book          = new();
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        i_in_valid    <= 1'b0;
        i_perm_in     <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(64'h0);
        send_request({WORD_W{1'b1}});
        send_request(64'hFEDC_BA98_7654_3210);
        send_request(64'h0123_4567_89AB_CDEF);
        send_request(64'h0000_0000_0011_2211);
        send_request(64'hABCD_EF01_2345_6789);

        write_length(5'd16);
        send_request(64'hFEDC_BA98_7654_3210);
        send_request(64'h0123_4567_89AB_CDEF);
        send_request(64'h5555_5555_5555_5554);
        send_request(64'h0);

        write_length(5'd0);
        send_request(64'hFEDC_BA98_7654_3210);
        write_length(5'd1);
        send_request(64'hFEDC_BA98_7654_3210);
        write_length(5'd2);
        send_request(64'h10);
        send_request(64'h01);
        write_length(5'd31);
        send_request(64'hFEDC_BA98_7654_3210);
        send_request(64'h0123_4567_89AB_CDEF);
        write_length(5'd17);
        send_request(64'h3210_FEDC_BA98_7654);

        for (int ph = 0; ph < PHASES; ph++) begin
            write_length((ph == 4) ? LEN_CFG_W'($urandom_range(0, 31)) : phase_len[ph]);
            calm = (ph == 2);
            for (int k = 0; k < PHASE_REQ; k++) begin
                send_request(make_word());
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (book.errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
